FILE: design/tsds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsds_pkg
// Shared types, constants and helpers for the touch sample denoise and
// smoothing block.
// ----------------------------------------------------------------------------
package tsds_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int THR_BITS     = 12;
    localparam int LIM_BITS     = 2 * THR_BITS;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS;
    localparam int DIST_BITS    = SQ_BITS + 1;
    localparam int HIST_DEPTH   = 4;
    localparam int FILL_BITS    = 3;
    localparam int SUM_BITS     = SAMPLE_BITS + 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int MIX_ROWS     = 3;

    typedef logic [SAMPLE_BITS-1:0]  t_coord;
    typedef logic [THR_BITS-1:0]     t_thr;
    typedef logic [LIM_BITS-1:0]     t_lim;
    typedef logic [SQ_BITS-1:0]      t_sq;
    typedef logic [DIST_BITS-1:0]    t_dist;
    typedef logic [FILL_BITS-1:0]    t_fill;
    typedef logic [SUM_BITS-1:0]     t_sum;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [3:0]              t_weight;
    typedef logic [2:0]              t_shift;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord p;
    } t_sample;

    // one pending result: sample, history fill after it, last of its run
    typedef struct packed {
        t_sample s;
        t_fill   fill;
        logic    last;
    } t_entry;

    localparam t_cfg_idx REG_VARIANCE_THR = t_cfg_idx'(0);
    localparam t_cfg_idx REG_DEJITTER_THR = t_cfg_idx'(1);

    localparam t_lim VAR_LIM_RST = t_lim'(400);
    localparam t_lim DJ_LIM_RST  = t_lim'(2500);

    localparam t_fill FILL_PASS  = t_fill'(0);
    localparam t_fill FILL_FIRST = t_fill'(1);
    localparam t_fill FILL_MAX   = t_fill'(HIST_DEPTH);

    localparam t_weight MIX_W [MIX_ROWS][HIST_DEPTH] = '{
        '{4'd5, 4'd3, 4'd0, 4'd0},
        '{4'd8, 4'd5, 4'd3, 4'd0},
        '{4'd6, 4'd4, 4'd3, 4'd3}
    };
    localparam t_shift MIX_SHIFT [MIX_ROWS] = '{3'd3, 3'd4, 3'd4};

    function automatic t_dist sq_dist(input t_sample a, input t_sample b);
        t_coord dx;
        t_coord dy;
        t_sq    qx;
        t_sq    qy;
        dx = (a.x > b.x) ? (a.x - b.x) : (b.x - a.x);
        dy = (a.y > b.y) ? (a.y - b.y) : (b.y - a.y);
        qx = t_sq'(dx) * t_sq'(dx);
        qy = t_sq'(dy) * t_sq'(dy);
        return {1'b0, qx} + {1'b0, qy};
    endfunction

endpackage
`default_nettype wire

FILE: design/tsds_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsds channel interfaces
// Valid/ready channels for raw samples, results and register writes.
// ----------------------------------------------------------------------------
interface tsds_in_if;
    logic                       valid;
    logic                       ready;
    logic [tsds_pkg::SAMPLE_BITS-1:0] touch_x;
    logic [tsds_pkg::SAMPLE_BITS-1:0] touch_y;
    logic [tsds_pkg::SAMPLE_BITS-1:0] touch_pressure;

    modport source (output valid, touch_x, touch_y, touch_pressure, input ready);
    modport sink   (input valid, touch_x, touch_y, touch_pressure, output ready);
endinterface

interface tsds_out_if;
    logic                       valid;
    logic                       ready;
    logic [tsds_pkg::SAMPLE_BITS-1:0] out_x;
    logic [tsds_pkg::SAMPLE_BITS-1:0] out_y;
    logic [tsds_pkg::SAMPLE_BITS-1:0] out_pressure;
    logic                       last_of_run;

    modport source (output valid, out_x, out_y, out_pressure, last_of_run, input ready);
    modport sink   (input valid, out_x, out_y, out_pressure, last_of_run, output ready);
endinterface

interface tsds_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tsds_pkg::CFG_IDX_BITS-1:0] index;
    logic [tsds_pkg::THR_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/touch_sample_denoise_smooth.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_denoise_smooth
// Variance spike filter followed by a 4-deep dejitter average.
// Path: input register, pending result queue, then the output register.
// Throughput: one request per cycle while each gives at most one result and
//   the result channel is not stalled; the smoothing stage emits one result
//   per cycle, so the two results of one request leave it one after the other.
// Reset: synchronous active low; clears filter state, queue and valids, and
//   loads thresholds 20 and 50. Smoothing history is not cleared.
// ----------------------------------------------------------------------------
module touch_sample_denoise_smooth (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tsds_in_if.sink      i_sample,
    tsds_out_if.source   o_result,
    tsds_cfg_if.sink     i_cfg
);

    // thresholds, kept squared
    tsds_pkg::t_lim r_var_lim;
    tsds_pkg::t_lim r_dj_lim;

    // input register
    logic              r_in_valid;
    tsds_pkg::t_sample r_in;

    // variance filter state
    logic              r_pen_down;
    logic              r_held_valid;
    logic              r_susp_valid;
    tsds_pkg::t_sample r_held;
    tsds_pkg::t_sample r_susp;
    logic              n_pen_down;
    logic              n_held_valid;
    logic              n_susp_valid;
    tsds_pkg::t_sample n_held;
    tsds_pkg::t_sample n_susp;

    // dejitter run tracking
    tsds_pkg::t_fill   r_dj_fill;
    tsds_pkg::t_sample r_dj_last;
    tsds_pkg::t_fill   n_dj_fill;
    tsds_pkg::t_sample n_dj_last;

    // stage one results
    logic              a_fire;
    logic [1:0]        a_n;
    logic              a_from_susp;
    tsds_pkg::t_sample a_s0;
    tsds_pkg::t_sample a_s1;
    tsds_pkg::t_fill   a_f0;
    tsds_pkg::t_fill   a_f1;
    tsds_pkg::t_dist   d_ch;
    tsds_pkg::t_dist   d_cs;
    tsds_pkg::t_dist   d_hl;
    tsds_pkg::t_dist   d_sl;
    tsds_pkg::t_dist   a_d0;
    logic              a_jump_c;
    logic              a_jump_s;

    // pending result queue
    tsds_pkg::t_entry  r_q [4];
    logic [1:0]        r_q_wr;
    logic [1:0]        r_q_rd;
    logic [2:0]        r_q_count;
    logic [2:0]        n_q_count;

    // smoothing stage
    logic              b_pop;
    tsds_pkg::t_entry  b_e;
    tsds_pkg::t_sample r_hist [tsds_pkg::HIST_DEPTH-1];
    tsds_pkg::t_sample b_win  [tsds_pkg::HIST_DEPTH];
    logic [1:0]        b_row;
    tsds_pkg::t_sum    b_sx;
    tsds_pkg::t_sum    b_sy;
    tsds_pkg::t_sum    b_sp;
    tsds_pkg::t_sum    b_hx;
    tsds_pkg::t_sum    b_hy;
    tsds_pkg::t_sum    b_hp;
    tsds_pkg::t_sample b_res;

    // output register
    logic              r_out_valid;
    tsds_pkg::t_sample r_out;
    logic              r_out_last;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_lim <= tsds_pkg::VAR_LIM_RST;
            r_dj_lim  <= tsds_pkg::DJ_LIM_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tsds_pkg::REG_VARIANCE_THR: begin
                    r_var_lim <= tsds_pkg::t_lim'(i_cfg.data) * tsds_pkg::t_lim'(i_cfg.data);
                end
                tsds_pkg::REG_DEJITTER_THR: begin
                    r_dj_lim <= tsds_pkg::t_lim'(i_cfg.data) * tsds_pkg::t_lim'(i_cfg.data);
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    assign a_fire         = r_in_valid && (r_q_count <= 3'd2);
    assign i_sample.ready = !r_in_valid || a_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in <= '{x: i_sample.touch_x, y: i_sample.touch_y, p: i_sample.touch_pressure};
        end
    end

    // variance filter
    assign d_ch     = tsds_pkg::sq_dist(r_in, r_held);
    assign d_cs     = tsds_pkg::sq_dist(r_in, r_susp);
    assign d_hl     = tsds_pkg::sq_dist(r_held, r_dj_last);
    assign d_sl     = tsds_pkg::sq_dist(r_susp, r_dj_last);
    assign a_jump_c = d_ch > tsds_pkg::t_dist'(r_var_lim);
    assign a_jump_s = d_cs > tsds_pkg::t_dist'(r_var_lim);

    always_comb begin
        n_pen_down   = r_pen_down;
        n_held_valid = r_held_valid;
        n_susp_valid = r_susp_valid;
        n_held       = r_held;
        n_susp       = r_susp;
        a_n          = 2'd0;
        a_s0         = r_held;
        a_s1         = r_in;
        a_from_susp  = 1'b0;
        if (r_in.p == '0) begin
            // pen up: release held, and the pen-up sample when pen was down
            a_n          = r_pen_down ? 2'd2 : 2'd1;
            n_pen_down   = 1'b0;
            n_held_valid = 1'b0;
            n_susp_valid = 1'b0;
            n_held       = r_in;
            if (r_pen_down) begin
                n_susp = r_in;
            end
        end else begin
            n_pen_down = 1'b1;
            if (!r_held_valid) begin
                n_held       = r_in;
                n_held_valid = 1'b1;
            end else if (a_jump_c) begin
                n_susp = r_in;
                if (r_susp_valid) begin
                    // second jump in a row: fast motion
                    a_s0        = r_susp;
                    a_from_susp = 1'b1;
                    if (a_jump_s) begin
                        a_n          = 2'd1;
                        n_held       = r_susp;
                        n_susp_valid = 1'b1;
                    end else begin
                        a_n          = 2'd2;
                        a_s1         = r_susp;
                        n_held       = r_in;
                        n_susp_valid = 1'b0;
                    end
                end else begin
                    n_susp_valid = 1'b1;
                end
            end else begin
                a_n          = 2'd1;
                n_susp_valid = 1'b0;
                n_held       = r_in;
            end
        end
    end

    // history fill for each released sample
    assign a_d0 = a_from_susp ? d_sl : d_hl;

    always_comb begin
        if (a_s0.p == '0) begin
            a_f0 = tsds_pkg::FILL_PASS;
        end else if (r_dj_fill == tsds_pkg::FILL_PASS
                     || a_d0 > tsds_pkg::t_dist'(r_dj_lim)) begin
            a_f0 = tsds_pkg::FILL_FIRST;
        end else if (r_dj_fill == tsds_pkg::FILL_MAX) begin
            a_f0 = tsds_pkg::FILL_MAX;
        end else begin
            a_f0 = r_dj_fill + tsds_pkg::t_fill'(1);
        end

        // a second non pen-up sample repeats the first one
        if (a_s1.p == '0) begin
            a_f1 = tsds_pkg::FILL_PASS;
        end else if (a_f0 == tsds_pkg::FILL_MAX) begin
            a_f1 = tsds_pkg::FILL_MAX;
        end else begin
            a_f1 = a_f0 + tsds_pkg::t_fill'(1);
        end

        case (a_n)
            2'd1:    n_dj_fill = a_f0;
            2'd2:    n_dj_fill = a_f1;
            default: n_dj_fill = r_dj_fill;
        endcase

        n_dj_last = r_dj_last;
        if (a_n != 2'd0 && a_s0.p != '0) begin
            n_dj_last = a_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_down   <= 1'b0;
            r_held_valid <= 1'b0;
            r_susp_valid <= 1'b0;
            r_held       <= '0;
            r_susp       <= '0;
            r_dj_fill    <= tsds_pkg::FILL_PASS;
        end else if (a_fire) begin
            r_pen_down   <= n_pen_down;
            r_held_valid <= n_held_valid;
            r_susp_valid <= n_susp_valid;
            r_held       <= n_held;
            r_susp       <= n_susp;
            r_dj_fill    <= n_dj_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_dj_last <= n_dj_last;
        end
    end

    // pending result queue
    assign b_pop     = (r_q_count != 3'd0) && (!r_out_valid || o_result.ready);
    assign n_q_count = r_q_count + (a_fire ? {1'b0, a_n} : 3'd0) - {2'b00, b_pop};
    assign b_e       = r_q[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= 2'd0;
            r_q_rd    <= 2'd0;
            r_q_count <= 3'd0;
        end else begin
            r_q_count <= n_q_count;
            if (a_fire) begin
                r_q_wr <= r_q_wr + a_n;
            end
            if (b_pop) begin
                r_q_rd <= r_q_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && a_n != 2'd0) begin
            r_q[r_q_wr] <= '{s: a_s0, fill: a_f0, last: (a_n == 2'd1)};
        end
        if (a_fire && a_n == 2'd2) begin
            r_q[r_q_wr + 2'd1] <= '{s: a_s1, fill: a_f1, last: 1'b1};
        end
    end

    // smoothing stage
    always_comb begin
        b_win[0] = b_e.s;
        for (int i = 1; i < tsds_pkg::HIST_DEPTH; i++) begin
            b_win[i] = (tsds_pkg::t_fill'(i) < b_e.fill) ? r_hist[i-1] : '0;
        end

        case (b_e.fill)
            3'd3:    b_row = 2'd1;
            3'd4:    b_row = 2'd2;
            default: b_row = 2'd0;
        endcase

        b_sx = '0;
        b_sy = '0;
        b_sp = '0;
        for (int i = 0; i < tsds_pkg::HIST_DEPTH; i++) begin
            b_sx = b_sx + tsds_pkg::t_sum'(b_win[i].x)
                        * tsds_pkg::t_sum'(tsds_pkg::MIX_W[b_row][i]);
            b_sy = b_sy + tsds_pkg::t_sum'(b_win[i].y)
                        * tsds_pkg::t_sum'(tsds_pkg::MIX_W[b_row][i]);
            b_sp = b_sp + tsds_pkg::t_sum'(b_win[i].p)
                        * tsds_pkg::t_sum'(tsds_pkg::MIX_W[b_row][i]);
        end
        b_hx = b_sx >> tsds_pkg::MIX_SHIFT[b_row];
        b_hy = b_sy >> tsds_pkg::MIX_SHIFT[b_row];
        b_hp = b_sp >> tsds_pkg::MIX_SHIFT[b_row];

        if (b_e.fill > tsds_pkg::FILL_FIRST) begin
            b_res.x = b_hx[tsds_pkg::SAMPLE_BITS-1:0];
            b_res.y = b_hy[tsds_pkg::SAMPLE_BITS-1:0];
            b_res.p = b_hp[tsds_pkg::SAMPLE_BITS-1:0];
        end else begin
            b_res = b_e.s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_pop && b_e.s.p != '0) begin
            r_hist[0] <= b_e.s;
            for (int i = 1; i < tsds_pkg::HIST_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_pop) begin
            r_out      <= b_res;
            r_out_last <= b_e.last;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_x        = r_out.x;
    assign o_result.out_y        = r_out.y;
    assign o_result.out_pressure = r_out.p;
    assign o_result.last_of_run  = r_out_last;

endmodule
`default_nettype wire

FILE: design/tsds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsds_checker
// Port-level checks for touch_sample_denoise_smooth, bound to the top level.
// ----------------------------------------------------------------------------
module tsds_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [tsds_pkg::SAMPLE_BITS-1:0] i_out_x,
    input wire logic [tsds_pkg::SAMPLE_BITS-1:0] i_out_y,
    input wire logic [tsds_pkg::SAMPLE_BITS-1:0] i_out_pressure,
    input wire logic                       i_out_last
);

    // no result right after reset
    a_reset_out: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // input side open right after reset
    a_reset_in: assert property (@(posedge i_clk) $past(!i_rst_n) |-> i_in_ready)
        else $error("input not ready right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_pressure) && $stable(i_out_last))
        else $error("stalled result changed");

    // second result of a request follows at once
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("second result of a request missing");

endmodule

bind touch_sample_denoise_smooth tsds_checker u_tsds_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_x        (o_result.out_x),
    .i_out_y        (o_result.out_y),
    .i_out_pressure (o_result.out_pressure),
    .i_out_last     (o_result.last_of_run)
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch sample denoise and smoothing block.
// Raw samples go in through the sample channel and each accepted request is
// run through a local variance/dejitter predictor; every result taken from
// the result channel is checked against the oldest predicted point. Runs
// directed spike, fast-motion and pen-up cases, threshold extremes, random
// strokes at several threshold settings, a long result stall and raw noise.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_WAIT_MAX = 5000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_HOLD     = 300;
    localparam int MIX_WT [3][4] = '{'{5, 3, 0, 0}, '{8, 5, 3, 0}, '{6, 4, 3, 3}};
    localparam int MIX_SH [3]    = '{3, 4, 4};

    typedef struct {
        tsds_pkg::t_coord x;
        tsds_pkg::t_coord y;
        tsds_pkg::t_coord p;
        logic             last;
    } t_point_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsds_in_if  samp_if ();
    tsds_out_if res_if ();
    tsds_cfg_if cfg_if ();

    touch_sample_denoise_smooth u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (samp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    tsds_pkg::t_thr    var_thr   = tsds_pkg::t_thr'(20);
    tsds_pkg::t_thr    dj_thr    = tsds_pkg::t_thr'(50);
    logic              pen_down  = 1'b0;
    logic              held_ok   = 1'b0;
    logic              susp_ok   = 1'b0;
    tsds_pkg::t_sample held_s    = '0;
    tsds_pkg::t_sample susp_s    = '0;
    tsds_pkg::t_sample hist [4]  = '{default: '0};
    int                hist_fill = 0;
    logic [1:0]        hist_head = 2'd0;

    t_point_result pending_points [$];
    int  err_count   = 0;
    int  hold_cycles = 0;
    bit  quiet       = 1'b0;

    function automatic int sq_span(tsds_pkg::t_sample a, tsds_pkg::t_sample b);
        int dx;
        int dy;
        dx = int'(a.x) - int'(b.x);
        dy = int'(a.y) - int'(b.y);
        return dx * dx + dy * dy;
    endfunction

    function automatic int clamp(int v, int lo);
        return (v < lo) ? lo : ((v > 4095) ? 4095 : v);
    endfunction

    function automatic tsds_pkg::t_sample dejitter_point(tsds_pkg::t_sample s);
        int sx;
        int sy;
        int sp;
        int row;
        logic [1:0] idx;
        tsds_pkg::t_sample r;
        sx = 0;
        sy = 0;
        sp = 0;
        if (s.p == '0) begin
            hist_fill = 0;
            return s;
        end
        idx = hist_head - 2'd1;
        if (hist_fill != 0 && sq_span(s, hist[idx]) > int'(dj_thr) * int'(dj_thr))
            hist_fill = 0;
        hist[hist_head] = s;
        if (hist_fill < 4)
            hist_fill++;
        if (hist_fill == 1) begin
            r = s;
        end else begin
            row = (hist_fill - 2) % 3;
            idx = hist_head;
            for (int i = 0; i < hist_fill; i++) begin
                sx += int'(hist[idx].x) * MIX_WT[row][i];
                sy += int'(hist[idx].y) * MIX_WT[row][i];
                sp += int'(hist[idx].p) * MIX_WT[row][i];
                idx = idx - 2'd1;
            end
            r.x = tsds_pkg::t_coord'(sx >> MIX_SH[row]);
            r.y = tsds_pkg::t_coord'(sy >> MIX_SH[row]);
            r.p = tsds_pkg::t_coord'(sp >> MIX_SH[row]);
        end
        hist_head = hist_head + 2'd1;
        return r;
    endfunction

    task automatic filter_sample(tsds_pkg::t_sample in_s);
        tsds_pkg::t_sample mid [2];
        tsds_pkg::t_sample cur;
        tsds_pkg::t_sample r;
        int n;
        bit again;
        n = 0;
        again = 1'b0;
        cur = in_s;
        for (int pass_no = 0; pass_no < 2; pass_no++) begin
            if (pass_no == 1) begin
                if (!again)
                    break;
                cur = susp_s;
                again = 1'b0;
            end
            if (cur.p == '0) begin
                if (pen_down) begin
                    again = 1'b1;
                    susp_s = cur;
                end
                pen_down = 1'b0;
                susp_ok = 1'b0;
                held_ok = 1'b0;
                mid[n] = held_s;
                n = n + 1;
                held_s = cur;
                continue;
            end
            pen_down = 1'b1;
            if (!held_ok) begin
                held_s = cur;
                held_ok = 1'b1;
                continue;
            end
            if (sq_span(cur, held_s) > int'(var_thr) * int'(var_thr)) begin
                if (susp_ok) begin
                    mid[n] = susp_s;
                    n = n + 1;
                    held_s = susp_s;
                    susp_ok = 1'b0;
                    again = 1'b1;
                end else begin
                    susp_ok = 1'b1;
                end
                susp_s = cur;
                continue;
            end
            susp_ok = 1'b0;
            mid[n] = held_s;
            n = n + 1;
            held_s = cur;
        end
        for (int k = 0; k < n; k++) begin
            r = dejitter_point(mid[k]);
            pending_points.push_back('{r.x, r.y, r.p, (k == n - 1)});
        end
    endtask

    task automatic send_sample(int x, int y, int p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            samp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        samp_if.valid          <= 1'b1;
        samp_if.touch_x        <= tsds_pkg::t_coord'(x);
        samp_if.touch_y        <= tsds_pkg::t_coord'(y);
        samp_if.touch_pressure <= tsds_pkg::t_coord'(p);
        do @(posedge i_clk); while (!samp_if.ready);
        filter_sample('{tsds_pkg::t_coord'(x), tsds_pkg::t_coord'(y),
                        tsds_pkg::t_coord'(p)});
    endtask

    task automatic cfg_write(tsds_pkg::t_cfg_idx idx, int value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= tsds_pkg::t_thr'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == tsds_pkg::REG_VARIANCE_THR)
            var_thr = tsds_pkg::t_thr'(value);
        else
            dj_thr = tsds_pkg::t_thr'(value);
    endtask

    task automatic wait_idle();
        int waited;
        samp_if.valid <= 1'b0;
        waited = 0;
        while (pending_points.size() != 0 && waited < IDLE_WAIT_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_points.size() != 0) begin
            err_count++;
            $display("%0t: expected %0d more results, actual 0", $time,
                     pending_points.size());
            pending_points.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_thresholds(int v, int d);
        wait_idle();
        cfg_write(tsds_pkg::REG_VARIANCE_THR, v);
        cfg_write(tsds_pkg::REG_DEJITTER_THR, d);
    endtask

    task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_point_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_points.size() == 0) begin
                err_count++;
                $display("%0t: expected no result, actual x=%0d y=%0d p=%0d",
                         $time, res_if.out_x, res_if.out_y, res_if.out_pressure);
            end else begin
                want = pending_points.pop_front();
                check_field("out_x", want.x, res_if.out_x);
                check_field("out_y", want.y, res_if.out_y);
                check_field("out_pressure", want.p, res_if.out_pressure);
                check_field("last_of_run", 12'(want.last), 12'(res_if.last_of_run));
            end
        end
    end

    // result side: random stall per result, or one long hold when asked
    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    task automatic test_directed();
        send_sample(0, 0, 0);
        send_sample(100, 100, 50);
        send_sample(105, 103, 60);
        send_sample(108, 104, 60);
        send_sample(300, 300, 60);
        send_sample(110, 106, 61);
        send_sample(400, 400, 70);
        send_sample(405, 402, 72);
        send_sample(0, 0, 0);
        send_sample(4095, 4095, 0);
        send_sample(4095, 4095, 4095);
        send_sample(4095, 4094, 4095);
        send_sample(4095, 4095, 1);
        send_sample(0, 0, 4095);
        send_sample(0, 1, 4095);
        send_sample(0, 0, 0);
    endtask

    task automatic test_register_extremes();
        set_thresholds(0, 0);
        send_sample(10, 10, 5);
        send_sample(11, 10, 5);
        send_sample(11, 10, 5);
        send_sample(12, 12, 9);
        send_sample(0, 0, 0);
        set_thresholds(4095, 4095);
        send_sample(0, 0, 4095);
        send_sample(4095, 4095, 4095);
        send_sample(4095, 0, 1);
        send_sample(0, 4095, 7);
        send_sample(0, 0, 0);
    endtask

    // pen strokes of random length with steps around both thresholds,
    // single spikes and fast moves, each ended by a pen-up
    task automatic run_strokes(int n_items);
        int sent;
        int len;
        int kind;
        int d;
        int px;
        int py;
        int pp;
        sent = 0;
        while (sent < n_items) begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
            pp = $urandom_range(1, 4095);
            len = $urandom_range(1, 40);
            for (int k = 0; k < len && sent < n_items; k++) begin
                kind = $urandom_range(0, 11);
                if (kind <= 6)
                    d = $urandom_range(0, var_thr / 3 + 2);
                else if (kind == 7)
                    d = (int'(var_thr) * 7) / 10 + $urandom_range(0, 2);
                else if (kind == 8)
                    d = (int'(dj_thr) * 7) / 10 + $urandom_range(0, 2);
                else if (kind == 10)
                    d = $urandom_range(0, 4095);
                else
                    d = $urandom_range(0, 3);
                if (kind == 9) begin
                    send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), pp);
                end else begin
                    px = clamp(px + ($urandom_range(0, 1) ? d : -d), 0);
                    py = clamp(py + ($urandom_range(0, 1) ? d : -d), 0);
                    if (kind == 11)
                        pp = $urandom_range(1, 4095);
                    else
                        pp = clamp(pp + $urandom_range(0, 32) - 16, 1);
                    send_sample(px, py, pp);
                end
                sent++;
            end
            send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
            sent++;
            if ($urandom_range(0, 3) == 0) begin
                send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
                sent++;
            end
        end
    endtask

    task automatic test_random_strokes();
        int v_set [5] = '{0, 4095, 20, 0, 4095};
        int d_set [5] = '{0, 4095, 50, 4095, 0};
        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 5)
                set_thresholds(v_set[ph], d_set[ph]);
            else
                set_thresholds($urandom_range(1, 200), $urandom_range(1, 400));
            quiet = (ph % 3 == 2);
            run_strokes(150);
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        set_thresholds(30, 80);
        quiet = 1'b1;
        hold_cycles = LONG_HOLD;
        run_strokes(60);
        quiet = 1'b0;
    endtask

    task automatic test_noise();
        set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095));
        for (int k = 0; k < 120; k++)
            send_sample($urandom_range(0, 4095), $urandom_range(0, 4095),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095));
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        samp_if.valid          <= 1'b0;
        samp_if.touch_x        <= '0;
        samp_if.touch_y        <= '0;
        samp_if.touch_pressure <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= tsds_pkg::REG_VARIANCE_THR;
        cfg_if.data            <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_random_strokes();
        test_backpressure();
        test_noise();
        wait_idle();

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: touch_sample_denoise_smooth.f
design/tsds_pkg.sv
design/tsds_if.sv
design/touch_sample_denoise_smooth.sv
design/tsds_checker.sv
test/tb_top.sv
